>>> design/hbap_pkg.sv
// ----------------------------------------------------------------------------
// hbap_pkg
// Shared constants, command codes and control/status types of the block
// assembler and padder.
// ----------------------------------------------------------------------------
package hbap_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int WORDS       = BLOCK_BYTES / 4;
  localparam int WIDX_W      = $clog2(WORDS);
  localparam int FILL_W      = $clog2(BLOCK_BYTES);
  localparam int LEN_BYTES   = 8;
  localparam int TOTAL_W     = 64;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_FINISH  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [WIDX_W-1:0] LAST_IDX   = WIDX_W'(WORDS - 1);
  localparam logic [WIDX_W-1:0] LEN_LO_IDX = WIDX_W'(WORDS - 2);
  localparam logic [FILL_W-1:0] FULL_FILL  = FILL_W'(BLOCK_BYTES - 1);
  localparam logic [FILL_W-1:0] TIGHT_FILL = FILL_W'(BLOCK_BYTES - LEN_BYTES);

  typedef struct packed {
    logic src_store;
    logic src_pad;
    logic with_len;
    logic final_blk;
  } mode_t;

  typedef struct packed {
    logic              add_byte;
    logic              restart;
    logic              emit_load;
    logic [WIDX_W-1:0] word_idx;
    mode_t             mode;
  } ctl_t;

  typedef struct packed {
    logic block_full;
    logic tight;
    logic out_free;
  } sts_t;

endpackage

>>> design/hbap_ctrl.sv
// ----------------------------------------------------------------------------
// hbap_ctrl
// Controller: takes commands, sequences the word emission of each block
// and the second block of a tight finish.
// ----------------------------------------------------------------------------
module hbap_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                msg_valid,
  output logic                msg_stall,
  input  logic [1:0]          cmd,
  input  hbap_pkg::sts_t      sts,
  output hbap_pkg::ctl_t      ctl
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                        state;
  logic                        state_next;
  logic [hbap_pkg::WIDX_W-1:0] widx;
  logic [hbap_pkg::WIDX_W-1:0] widx_next;
  hbap_pkg::mode_t             mode;
  hbap_pkg::mode_t             mode_next;
  logic                        second;
  logic                        second_next;

  always_comb begin
    state_next    = state;
    widx_next     = widx;
    mode_next     = mode;
    second_next   = second;
    msg_stall     = (state != ST_IDLE);
    ctl.add_byte  = 1'b0;
    ctl.restart   = 1'b0;
    ctl.emit_load = 1'b0;
    ctl.word_idx  = widx;
    ctl.mode      = mode;
    unique case (state)
      ST_IDLE: begin
        if (msg_valid) begin
          unique case (cmd)
            hbap_pkg::CMD_ADD: begin
              ctl.add_byte = 1'b1;
              if (sts.block_full) begin
                state_next  = ST_EMIT;
                widx_next   = '0;
                mode_next   = '{src_store: 1'b1, src_pad: 1'b0,
                                with_len: 1'b0, final_blk: 1'b0};
                second_next = 1'b0;
              end
            end
            hbap_pkg::CMD_FINISH: begin
              state_next = ST_EMIT;
              widx_next  = '0;
              if (sts.tight) begin
                mode_next   = '{src_store: 1'b0, src_pad: 1'b1,
                                with_len: 1'b0, final_blk: 1'b0};
                second_next = 1'b1;
              end else begin
                mode_next   = '{src_store: 1'b0, src_pad: 1'b1,
                                with_len: 1'b1, final_blk: 1'b1};
                second_next = 1'b0;
              end
            end
            hbap_pkg::CMD_RESTART: begin
              ctl.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          ctl.emit_load = 1'b1;
          if (widx == hbap_pkg::LAST_IDX) begin
            if (second) begin
              widx_next   = '0;
              mode_next   = '{src_store: 1'b0, src_pad: 1'b0,
                              with_len: 1'b1, final_blk: 1'b1};
              second_next = 1'b0;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            widx_next = widx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      widx   <= '0;
      mode   <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      widx   <= widx_next;
      mode   <= mode_next;
      second <= second_next;
    end
  end

endmodule

>>> design/hbap_datapath.sv
// ----------------------------------------------------------------------------
// hbap_datapath
// Datapath: block word store with byte writes, fill and length counters,
// word formation with padding and length, and the output register.
// ----------------------------------------------------------------------------
module hbap_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           data_byte,
  input  hbap_pkg::ctl_t       ctl,
  output hbap_pkg::sts_t       sts,
  output logic                 word_valid,
  input  logic                 word_stall,
  output logic [31:0]          block_word,
  output logic [4:0]           word_index,
  output logic                 end_of_block,
  output logic                 end_of_message
);

  logic [31:0]                  store [hbap_pkg::WORDS];
  logic [hbap_pkg::FILL_W-1:0]  fill;
  logic [hbap_pkg::TOTAL_W-1:0] total;
  logic [hbap_pkg::TOTAL_W-1:0] bits;
  logic [hbap_pkg::WIDX_W-1:0]  pidx;
  logic [1:0]                   lane;
  logic [4:0]                   lane_sh;
  logic [31:0]                  pad_word;
  logic [31:0]                  emit_word;
  logic                         last_word;

  assign pidx    = fill[hbap_pkg::FILL_W-1:2];
  assign lane    = fill[1:0];
  assign lane_sh = {lane, 3'b000};
  assign bits    = {total[hbap_pkg::TOTAL_W-4:0], 3'b000};
  assign pad_word = (store[pidx] & ~(32'hFFFF_FFFF << lane_sh))
                  | ({24'h0, hbap_pkg::PAD_MARK} << lane_sh);
  assign last_word = (ctl.word_idx == hbap_pkg::LAST_IDX);

  assign sts.block_full = (fill == hbap_pkg::FULL_FILL);
  assign sts.tight      = (fill >= hbap_pkg::TIGHT_FILL);
  assign sts.out_free   = !word_valid || !word_stall;

  always_comb begin
    emit_word = '0;
    if (ctl.mode.src_store) begin
      emit_word = store[ctl.word_idx];
    end
    if (ctl.mode.src_pad) begin
      if (ctl.word_idx < pidx) begin
        emit_word = store[ctl.word_idx];
      end else if (ctl.word_idx == pidx) begin
        emit_word = pad_word;
      end
    end
    if (ctl.mode.with_len) begin
      if (ctl.word_idx == hbap_pkg::LEN_LO_IDX) begin
        emit_word = emit_word | bits[31:0];
      end else if (last_word) begin
        emit_word = emit_word | bits[63:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add_byte) begin
      store[pidx][lane_sh +: 8] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      total <= '0;
    end else if (ctl.restart) begin
      fill  <= '0;
      total <= '0;
    end else if (ctl.add_byte) begin
      total <= total + 1'b1;
      if (sts.block_full) begin
        fill <= '0;
      end else begin
        fill <= fill + 1'b1;
      end
    end else if (ctl.emit_load && ctl.mode.src_pad && last_word) begin
      fill <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (ctl.emit_load) begin
      word_valid <= 1'b1;
    end else if (!word_stall) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_load) begin
      block_word     <= emit_word;
      word_index     <= 5'(ctl.word_idx);
      end_of_block   <= last_word;
      end_of_message <= last_word && ctl.mode.final_blk;
    end
  end

endmodule

>>> design/hash_block_assembler_padder.sv
// ----------------------------------------------------------------------------
// hash_block_assembler_padder
// Message byte collector and Merkle-Damgard padder feeding a hash core.
// ----------------------------------------------------------------------------
// Bytes (cmd 0) are taken one per cycle into a word store while the input
// is not stalled. The byte that completes a block stalls the input while
// the block leaves as one 32-bit little-endian word per cycle when the
// output does not stall. A finish (cmd 1) emits one padded block with the
// bit length in its last two words, or two blocks when fewer than eight
// bytes remain after the pad byte; the input stalls until the last word of
// the last block is loaded into the output register. Restart (cmd 2) clears
// the fill count and the message length.
// ----------------------------------------------------------------------------
module hash_block_assembler_padder (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [31:0] block_word,
  output logic [4:0]  word_index,
  output logic        end_of_block,
  output logic        end_of_message
);

  hbap_pkg::ctl_t ctl;
  hbap_pkg::sts_t sts;

  hbap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .cmd       (cmd),
    .sts       (sts),
    .ctl       (ctl)
  );

  hbap_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .ctl            (ctl),
    .sts            (sts),
    .word_valid     (word_valid),
    .word_stall     (word_stall),
    .block_word     (block_word),
    .word_index     (word_index),
    .end_of_block   (end_of_block),
    .end_of_message (end_of_message)
  );

endmodule

>>> dv/hbap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hbap_checker
// Watches both channels of the block assembler and padder. It keeps its own
// copy of the block buffer and the message length, works out every word that
// each accepted item should emit, and compares the emitted words in order.
// ----------------------------------------------------------------------------
module hbap_checker
  import hbap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  input  logic        msg_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  input  logic        word_valid,
  input  logic        word_stall,
  input  logic [31:0] block_word,
  input  logic [4:0]  word_index,
  input  logic        end_of_block,
  input  logic        end_of_message,
  output int          errors,
  output int          pending,
  output int          words_seen,
  output int          msgs_done
);

  typedef struct {
    logic [31:0] word;
    logic [4:0]  idx;
    logic        eob;
    logic        eom;
  } block_word_t;

  block_word_t  word_q[$];
  logic [7:0]   blk_bytes[BLOCK_BYTES];
  int           fill;
  logic [63:0]  total_bytes;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  task automatic queue_block(input bit last);
    block_word_t e;
    for (int w = 0; w < WORDS; w++) begin
      e.word = {blk_bytes[4*w+3], blk_bytes[4*w+2], blk_bytes[4*w+1], blk_bytes[4*w]};
      e.idx  = 5'(w);
      e.eob  = (w == WORDS - 1);
      e.eom  = last && (w == WORDS - 1);
      word_q.insert(word_q.size(), e);
    end
  endtask

  task automatic absorb_item(input logic [1:0] c, input logic [7:0] b);
    logic [63:0] bits;
    case (c)
      CMD_ADD: begin
        blk_bytes[fill] = b;
        fill++;
        total_bytes++;
        if (fill == BLOCK_BYTES) begin
          queue_block(1'b0);
          fill = 0;
        end
      end
      CMD_FINISH: begin
        blk_bytes[fill] = PAD_MARK;
        for (int i = fill + 1; i < BLOCK_BYTES; i++) blk_bytes[i] = 8'h00;
        if (BLOCK_BYTES - (fill + 1) < LEN_BYTES) begin
          queue_block(1'b0);
          for (int i = 0; i < BLOCK_BYTES; i++) blk_bytes[i] = 8'h00;
        end
        bits = total_bytes << 3;
        for (int i = 0; i < LEN_BYTES; i++)
          blk_bytes[BLOCK_BYTES - LEN_BYTES + i] = bits[8*i +: 8];
        queue_block(1'b1);
        fill = 0;
        msgs_done++;
      end
      CMD_RESTART: begin
        fill = 0;
        total_bytes = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    block_word_t e;
    if (rst) begin
      word_q.delete();
      fill = 0;
      total_bytes = '0;
      errors = 0;
      words_seen = 0;
      msgs_done = 0;
    end else begin
      if (word_valid && !word_stall) begin
        if (word_q.size() == 0) begin
          errors++;
          $error("unexpected word %0h at index %0d", block_word, word_index);
        end else begin
          e = word_q.pop_front();
          check_field("block_word", e.word, block_word);
          check_field("word_index", 32'(e.idx), 32'(word_index));
          check_field("end_of_block", 32'(e.eob), 32'(end_of_block));
          check_field("end_of_message", 32'(e.eom), 32'(end_of_message));
          words_seen++;
        end
      end
      if (msg_valid && !msg_stall) absorb_item(cmd, data_byte);
    end
    pending = word_q.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives byte, finish, restart and unused commands into the block
// assembler and padder under varying sender gaps and receiver stalls; the
// checker beside the block predicts and compares every emitted block word.
// ----------------------------------------------------------------------------
module tb;
  import hbap_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         ITEMS      = 360;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        msg_valid = 1'b0;
  logic        msg_stall;
  logic [1:0]  cmd = CMD_ADD;
  logic [7:0]  data_byte = 8'h00;
  logic        word_valid;
  logic        word_stall = 1'b0;
  logic [31:0] block_word;
  logic [4:0]  word_index;
  logic        end_of_block;
  logic        end_of_message;

  int errors, pending, words_seen, msgs_done;
  int send_idle_pct = 13;
  int recv_stall_pct = 76;
  int item_count = 0;

  always #5 clk = ~clk;

  hash_block_assembler_padder dut (
    .clk(clk), .rst(rst),
    .msg_valid(msg_valid), .msg_stall(msg_stall), .cmd(cmd), .data_byte(data_byte),
    .word_valid(word_valid), .word_stall(word_stall), .block_word(block_word),
    .word_index(word_index), .end_of_block(end_of_block), .end_of_message(end_of_message)
  );

  hbap_checker chk (
    .clk(clk), .rst(rst),
    .msg_valid(msg_valid), .msg_stall(msg_stall), .cmd(cmd), .data_byte(data_byte),
    .word_valid(word_valid), .word_stall(word_stall), .block_word(block_word),
    .word_index(word_index), .end_of_block(end_of_block), .end_of_message(end_of_message),
    .errors(errors), .pending(pending), .words_seen(words_seen), .msgs_done(msgs_done)
  );

  always @(posedge clk) begin
    word_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(input logic [1:0] c, input logic [7:0] b);
    if (c != CMD_UNUSED) begin
      if (item_count < ITEMS / 3) begin
        send_idle_pct = 13;
        recv_stall_pct = 76;
      end else if (item_count < 2 * ITEMS / 3) begin
        send_idle_pct = 76;
        recv_stall_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      item_count++;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      msg_valid <= 1'b0;
      @(posedge clk);
    end
    msg_valid <= 1'b1;
    cmd <= c;
    data_byte <= b;
    // hold until the item is taken
    @(negedge clk);
    while (msg_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) send_item(CMD_UNUSED, 8'($urandom));
      send_item(CMD_ADD, 8'($urandom));
    end
    send_item(CMD_FINISH, 8'($urandom));
  endtask

  initial begin
    int r, len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_item(CMD_RESTART, 8'hFF);
    send_item(CMD_FINISH, 8'h5A);
    send_item(CMD_ADD, 8'h00);
    send_item(CMD_ADD, 8'hFF);
    send_item(CMD_ADD, 8'hA5);
    send_item(CMD_FINISH, 8'hFF);
    send_item(CMD_UNUSED, 8'hFF);
    send_item(CMD_UNUSED, 8'h00);
    send_item(CMD_ADD, 8'h01);
    send_item(CMD_ADD, 8'h80);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_ADD, 8'h7F);
    send_item(CMD_FINISH, 8'h33);

    send_message(BLOCK_BYTES - LEN_BYTES);
    send_message(BLOCK_BYTES);

    while (item_count < ITEMS) begin
      r = $urandom_range(99);
      if (r < 75) begin
        if ($urandom_range(1) == 1) send_item(CMD_RESTART, 8'($urandom));
        r = $urandom_range(99);
        if (r < 40) len = $urandom_range(10);
        else if (r < 75) len = $urandom_range(BLOCK_BYTES - LEN_BYTES - 4, BLOCK_BYTES + 2);
        else if (r < 90) len = $urandom_range(BLOCK_BYTES - 1);
        else len = $urandom_range(BLOCK_BYTES, 2 * BLOCK_BYTES + 4);
        if (len > ITEMS - item_count) len = ITEMS - item_count;
        send_message(len);
      end else if (r < 88) begin
        len = $urandom_range(1, 20);
        for (int i = 0; i < len; i++) send_item(CMD_ADD, 8'($urandom));
        send_item(CMD_RESTART, 8'($urandom));
      end else if (r < 94) begin
        send_item(CMD_UNUSED, 8'($urandom));
      end else begin
        send_item(CMD_FINISH, 8'($urandom));
      end
    end
    msg_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4 * WORDS) @(posedge clk);

    $display("sent %0d commands covering %0d finished messages", item_count, msgs_done);
    $display("checked %0d block words across three gap and stall mixes", words_seen);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
